FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked checks with and without reset masking
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_RST(lbl, prop)
`endif
`endif

FILE: rtl/pc3_pkg.sv
// ----------------------------------------------------------------------------
// pc3_pkg
// shared types, constants and helpers of the pressure compensation pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pc3_pkg;

  localparam int DIV_W      = 32;
  localparam int SIDE_W     = 53;
  localparam int UP_W       = 19;
  localparam int HPA_W      = 26;
  localparam int IDX_W      = 3;

  localparam logic [IDX_W-1:0] REG_AC1_AC2 = 3'd0;
  localparam logic [IDX_W-1:0] REG_AC3_AC4 = 3'd1;
  localparam logic [IDX_W-1:0] REG_AC5_AC6 = 3'd2;
  localparam logic [IDX_W-1:0] REG_B1_B2   = 3'd3;
  localparam logic [IDX_W-1:0] REG_MC_MD   = 3'd4;

  localparam logic [31:0] B6_OFFSET   = 32'd4000;
  localparam logic [31:0] QC_MUL      = 32'd3038;
  localparam logic [31:0] QC_LIN      = 32'hFFFF_E343; // -7357
  localparam logic [31:0] QC_ADD      = 32'd3791;
  localparam logic [31:0] B7_SCALE    = 32'd6250;      // 50000 >> 3
  localparam logic [31:0] B4_BIAS     = 32'd32768;
  localparam logic [31:0] RECIP_100   = 32'h51EB_851F;
  localparam int          RECIP_SHIFT = 37;

  typedef struct packed {
    logic              valid;
    logic [DIV_W-1:0]  dvd;
    logic [DIV_W-1:0]  dvs;
    logic [SIDE_W-1:0] side;
  } div_in_t;

  typedef struct packed {
    logic              valid;
    logic [DIV_W-1:0]  quo;
    logic [SIDE_W-1:0] side;
  } div_out_t;

  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
    return 32'($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/pc3_udiv.sv
// ----------------------------------------------------------------------------
// pc3_udiv
// 32-bit unsigned restoring divider, one quotient bit per pipeline stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pc3_udiv (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire pc3_pkg::div_in_t   din,
  output pc3_pkg::div_out_t       dout
);

  localparam int N = pc3_pkg::DIV_W;

  logic                      v_r    [N];
  logic [N-1:0]              rem_r  [N];
  logic [N-1:0]              wq_r   [N];
  logic [N-1:0]              dvs_r  [N];
  logic [pc3_pkg::SIDE_W-1:0] side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                       v_in;
    logic [N-1:0]               rem_in;
    logic [N-1:0]               wq_in;
    logic [N-1:0]               dvs_in;
    logic [pc3_pkg::SIDE_W-1:0] side_in;
    logic [N:0]                 trial;
    logic                       ge;
    logic [N-1:0]               rem_nxt;
    logic [N-1:0]               wq_nxt;

    if (k == 0) begin : g_first
      assign v_in    = din.valid;
      assign rem_in  = '0;
      assign wq_in   = din.dvd;
      assign dvs_in  = din.dvs;
      assign side_in = din.side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign wq_in   = wq_r[k-1];
      assign dvs_in  = dvs_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign trial   = {rem_in, wq_in[N-1]};
    assign ge      = trial >= {1'b0, dvs_in};
    assign rem_nxt = ge ? N'(trial - {1'b0, dvs_in}) : trial[N-1:0];
    assign wq_nxt  = {wq_in[N-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        wq_r[k]   <= wq_nxt;
        dvs_r[k]  <= dvs_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign dout.valid = v_r[N-1];
  assign dout.quo   = wq_r[N-1];
  assign dout.side  = side_r[N-1];

endmodule
`default_nettype wire

FILE: rtl/pressure_compensation_oss3_top.sv
// ----------------------------------------------------------------------------
// pressure_compensation_oss3_top
// integer barometer compensation at oversampling 3, fully pipelined
// ----------------------------------------------------------------------------
// usage:
//   in_* carries one beat per sample: raw temperature and raw pressure word.
//   out_* returns one beat per sample: pressure in Pa, in hPa, error flag.
//   cfg_* writes the five calibration words; write only while the pipe is empty.
// pipeline: 80 register stages (16 arithmetic stages plus two 32-stage dividers,
//   one quotient bit per stage).
// throughput: one beat per cycle while the pipe is not stalled; every stage,
//   divider stages included, takes a new sample each cycle that the pipe advances.
// stall: the whole pipe holds when out_tvalid is high and out_tready low;
//   in_tready then drops and nothing is lost or repeated.
// reset: rst_n low clears all valid bits and the calibration words to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pressure_compensation_oss3_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // raw_temperature[15:0], raw_pressure[39:16]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // pressure_pa[31:0], pressure_hpa[57:32],
                                       // div_error[58], zero[63:59]
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam int UPW = pc3_pkg::UP_W;
  localparam int HW  = pc3_pkg::HPA_W;

  logic [31:0] cal_r [5];
  logic        adv;

  // calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) cal_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pc3_pkg::REG_AC1_AC2: cal_r[0] <= cfg_wdata;
        pc3_pkg::REG_AC3_AC4: cal_r[1] <= cfg_wdata;
        pc3_pkg::REG_AC5_AC6: cal_r[2] <= cfg_wdata;
        pc3_pkg::REG_B1_B2:   cal_r[3] <= cfg_wdata;
        pc3_pkg::REG_MC_MD:   cal_r[4] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = pc3_pkg::sext16(cal_r[0][31:16]);
  assign ac2 = pc3_pkg::sext16(cal_r[0][15:0]);
  assign ac3 = pc3_pkg::sext16(cal_r[1][31:16]);
  assign ac4 = {16'd0, cal_r[1][15:0]};
  assign ac5 = {16'd0, cal_r[2][31:16]};
  assign ac6 = {16'd0, cal_r[2][15:0]};
  assign b1  = pc3_pkg::sext16(cal_r[3][31:16]);
  assign b2  = pc3_pkg::sext16(cal_r[3][15:0]);
  assign mc  = pc3_pkg::sext16(cal_r[4][31:16]);
  assign md  = pc3_pkg::sext16(cal_r[4][15:0]);

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // stage registers
  logic            s0_v_r, s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r;
  logic            s7_v_r, s8_v_r, s9_v_r, s10_v_r, s11_v_r, s12_v_r, s13_v_r, s14_v_r;
  logic [15:0]     s0_ut_r;
  logic [UPW-1:0]  s0_up_r, s1_up_r, s2_up_r, s3_up_r, s4_up_r, s5_up_r, s6_up_r;
  logic [31:0]     s1_m_r;
  logic [31:0]     s2_x1_r, s2_dvd_r, s2_dvs_r;
  logic            s2_neg_r, s2_err_r;
  logic [31:0]     s3_b6_r;
  logic            s3_err_r, s4_err_r, s5_err_r, s6_err_r, s7_err_r, s8_err_r, s9_err_r;
  logic            s10_err_r, s11_err_r, s12_err_r, s13_err_r, s14_err_r;
  logic [31:0]     s4_sq_r, s4_pac2_r, s4_pac3_r;
  logic [31:0]     s5_mb2_r, s5_mb1_r, s5_x2a_r, s5_x1c_r;
  logic [31:0]     s6_b3_r, s6_x3_r;
  logic [31:0]     s7_b4_r, s7_b7p_r;
  logic [31:0]     s8_b7_r, s8_b4_r;
  logic [31:0]     s9_dvd_r, s9_dvs_r;
  logic            s9_flag_r;
  logic [31:0]     s10_p_r;
  logic [31:0]     s11_sq_r, s11_lin_r, s11_p_r;
  logic [31:0]     s12_t1_r, s12_x2_r, s12_p_r;
  logic [31:0]     s13_p_r;
  logic [63:0]     s14_prod_r;
  logic [31:0]     s14_p_r;
  logic            s14_neg_r;
  logic            out_v_r, out_err_r;
  logic [31:0]     out_pa_r;
  logic [HW-1:0]   out_hpa_r;

  pc3_pkg::div_in_t  d1_in, d2_in;
  pc3_pkg::div_out_t d1_out, d2_out;

  // combinational helpers
  logic [31:0] s2_x1_nxt, s2_den_nxt, s2_a_nxt;
  logic [31:0] d1_x1, d1_x2, s3_b6_nxt;
  logic [UPW-1:0] d1_up;
  logic        d1_err, d1_neg;
  logic [31:0] s5_b6sq;
  logic [31:0] s6_x3a, s6_v, s6_b3_nxt, s6_x3_nxt;
  logic [31:0] s7_b4_nxt;
  logic [31:0] s10_p_nxt;
  logic [31:0] s11_ps8;
  logic [31:0] s13_p_nxt;
  logic [31:0] s14_mag;
  logic [26:0] out_q;
  logic [31:0] out_hpa32;

  assign s2_x1_nxt  = pc3_pkg::asr32(s1_m_r, 15);
  assign s2_den_nxt = s2_x1_nxt + md;
  assign s2_a_nxt   = mc << 11;

  assign d1_in.valid = s2_v_r;
  assign d1_in.dvd   = s2_dvd_r;
  assign d1_in.dvs   = s2_dvs_r;
  assign d1_in.side  = {s2_x1_r, s2_up_r, s2_err_r, s2_neg_r};

  pc3_udiv u_div_temp (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .din   (d1_in),
    .dout  (d1_out)
  );

  assign d1_x1  = d1_out.side[52:21];
  assign d1_up  = d1_out.side[20:2];
  assign d1_err = d1_out.side[1];
  assign d1_neg = d1_out.side[0];
  assign d1_x2  = d1_neg ? (32'd0 - d1_out.quo) : d1_out.quo;
  assign s3_b6_nxt = d1_x1 + d1_x2 - pc3_pkg::B6_OFFSET;

  assign s5_b6sq = pc3_pkg::asr32(s4_sq_r, 12);

  assign s6_x3a    = pc3_pkg::asr32(s5_mb2_r, 11) + s5_x2a_r;
  assign s6_v      = (((ac1 << 2) + s6_x3a) << 3) + 32'd2;
  assign s6_b3_nxt = pc3_pkg::asr32(s6_v + (s6_v[31] ? 32'd3 : 32'd0), 2);
  assign s6_x3_nxt = pc3_pkg::asr32(s5_x1c_r + pc3_pkg::asr32(s5_mb1_r, 16) + 32'd2, 2);

  assign s7_b4_nxt = (ac4 * (s6_x3_r + pc3_pkg::B4_BIAS)) >> 15;

  assign d2_in.valid = s9_v_r;
  assign d2_in.dvd   = s9_dvd_r;
  assign d2_in.dvs   = s9_dvs_r;
  assign d2_in.side  = {51'd0, s9_err_r, s9_flag_r};

  pc3_udiv u_div_press (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .din   (d2_in),
    .dout  (d2_out)
  );

  assign s10_p_nxt = d2_out.side[0] ? (d2_out.quo << 1) : d2_out.quo;
  assign s11_ps8   = pc3_pkg::asr32(s10_p_r, 8);
  assign s13_p_nxt = s12_p_r + pc3_pkg::asr32(pc3_pkg::asr32(s12_t1_r, 16) + s12_x2_r
                     + pc3_pkg::QC_ADD, 4);
  assign s14_mag   = s13_p_r[31] ? (32'd0 - s13_p_r) : s13_p_r;
  assign out_q     = s14_prod_r[63:pc3_pkg::RECIP_SHIFT];
  assign out_hpa32 = s14_neg_r ? (32'd0 - {5'd0, out_q}) : {5'd0, out_q};

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {s0_v_r, s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r} <= '0;
      {s8_v_r, s9_v_r, s10_v_r, s11_v_r, s12_v_r, s13_v_r, s14_v_r, out_v_r} <= '0;
    end else if (adv) begin
      s0_v_r  <= in_tvalid;
      s1_v_r  <= s0_v_r;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= d1_out.valid;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      s6_v_r  <= s5_v_r;
      s7_v_r  <= s6_v_r;
      s8_v_r  <= s7_v_r;
      s9_v_r  <= s8_v_r;
      s10_v_r <= d2_out.valid;
      s11_v_r <= s10_v_r;
      s12_v_r <= s11_v_r;
      s13_v_r <= s12_v_r;
      s14_v_r <= s13_v_r;
      out_v_r <= s14_v_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_ut_r   <= in_tdata[15:0];
      s0_up_r   <= in_tdata[39:21];

      s1_m_r    <= ({16'd0, s0_ut_r} - ac6) * ac5;
      s1_up_r   <= s0_up_r;

      s2_x1_r   <= s2_x1_nxt;
      s2_up_r   <= s1_up_r;
      s2_err_r  <= s2_den_nxt == 32'd0;
      s2_neg_r  <= s2_a_nxt[31] ^ s2_den_nxt[31];
      s2_dvd_r  <= s2_a_nxt[31] ? (32'd0 - s2_a_nxt) : s2_a_nxt;
      s2_dvs_r  <= (s2_den_nxt == 32'd0) ? 32'd1
                   : (s2_den_nxt[31] ? (32'd0 - s2_den_nxt) : s2_den_nxt);

      s3_b6_r   <= s3_b6_nxt;
      s3_up_r   <= d1_up;
      s3_err_r  <= d1_err;

      s4_sq_r   <= s3_b6_r * s3_b6_r;
      s4_pac2_r <= ac2 * s3_b6_r;
      s4_pac3_r <= ac3 * s3_b6_r;
      s4_up_r   <= s3_up_r;
      s4_err_r  <= s3_err_r;

      s5_mb2_r  <= b2 * s5_b6sq;
      s5_mb1_r  <= b1 * s5_b6sq;
      s5_x2a_r  <= pc3_pkg::asr32(s4_pac2_r, 11);
      s5_x1c_r  <= pc3_pkg::asr32(s4_pac3_r, 13);
      s5_up_r   <= s4_up_r;
      s5_err_r  <= s4_err_r;

      s6_b3_r   <= s6_b3_nxt;
      s6_x3_r   <= s6_x3_nxt;
      s6_up_r   <= s5_up_r;
      s6_err_r  <= s5_err_r;

      s7_b4_r   <= s7_b4_nxt;
      s7_b7p_r  <= {13'd0, s6_up_r} - s6_b3_r;
      s7_err_r  <= s6_err_r || (s7_b4_nxt == 32'd0);

      s8_b7_r   <= s7_b7p_r * pc3_pkg::B7_SCALE;
      s8_b4_r   <= s7_b4_r;
      s8_err_r  <= s7_err_r;

      s9_flag_r <= s8_b7_r[31];
      s9_dvd_r  <= s8_b7_r[31] ? s8_b7_r : (s8_b7_r << 1);
      s9_dvs_r  <= (s8_b4_r == 32'd0) ? 32'd1 : s8_b4_r;
      s9_err_r  <= s8_err_r;

      s10_p_r   <= s10_p_nxt;
      s10_err_r <= d2_out.side[1];

      s11_sq_r  <= s11_ps8 * s11_ps8;
      s11_lin_r <= pc3_pkg::QC_LIN * s10_p_r;
      s11_p_r   <= s10_p_r;
      s11_err_r <= s10_err_r;

      s12_t1_r  <= s11_sq_r * pc3_pkg::QC_MUL;
      s12_x2_r  <= pc3_pkg::asr32(s11_lin_r, 16);
      s12_p_r   <= s11_p_r;
      s12_err_r <= s11_err_r;

      s13_p_r   <= s13_p_nxt;
      s13_err_r <= s12_err_r;

      s14_prod_r <= {32'd0, s14_mag} * {32'd0, pc3_pkg::RECIP_100};
      s14_neg_r  <= s13_p_r[31];
      s14_p_r    <= s13_p_r;
      s14_err_r  <= s13_err_r;

      out_err_r <= s14_err_r;
      out_pa_r  <= s14_err_r ? 32'd0 : s14_p_r;
      out_hpa_r <= s14_err_r ? '0 : out_hpa32[HW-1:0];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_err_r, out_hpa_r, out_pa_r};

  `ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid)
  `ASSERT_CLK(a_err_zero, out_tvalid && out_tdata[58] |-> out_tdata[57:0] == 58'd0)
  `ASSERT_CLK(a_hpa_sign, out_tvalid && !out_tdata[31] |-> !out_tdata[57])
  `ASSERT_CLK(a_stall_hold, !adv |=> $stable({s0_v_r, s3_v_r, s10_v_r, s14_v_r}))

endmodule
`default_nettype wire
